@@ design/line_framer_with_overflow_drop_defines.svh @@
// Assertion macros for the line framer.
`ifndef LINE_FRAMER_WITH_OVERFLOW_DROP_DEFINES_SVH
`define LINE_FRAMER_WITH_OVERFLOW_DROP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LFOD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line framer check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LFOD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line framer check failed");
`else
`define LFOD_ASSERT_NOW(lbl, ante, cons)
`define LFOD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/lfod_pkg.sv @@
package lfod_pkg;

  localparam int CFG_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_RD,
    ST_EMIT
  } lfod_state_t;

  typedef struct packed {
    logic              has_char;
    logic [BYTE_W-1:0] line_char;
    logic              run_last;
    logic [CNT_W-1:0]  lines_total;
    logic [CNT_W-1:0]  drops_total;
  } lfod_res_t;

endpackage

@@ design/lfod_ram.sv @@
module lfod_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/lfod_ctl.sv @@
module lfod_ctl #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lfod_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic [lfod_pkg::CFG_W-1:0]        max_chars,
  input  logic                              out_free,
  output logic                              res_load,
  output lfod_pkg::lfod_res_t               res,
  output logic                              ram_wr_en,
  output logic [$clog2(LINE_DEPTH)-1:0]     ram_wr_addr,
  output logic [lfod_pkg::BYTE_W-1:0]       ram_wr_data,
  output logic                              ram_rd_en,
  output logic [$clog2(LINE_DEPTH)-1:0]     ram_rd_addr,
  input  logic [lfod_pkg::BYTE_W-1:0]       ram_rd_data
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = lfod_pkg::CFG_W + 1;
  localparam logic [CW-1:0] MAX_LIM = CW'(LINE_DEPTH - 1);

  lfod_pkg::lfod_state_t state_r, state_nxt;
  logic [lfod_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [AW-1:0]               fill_r, fill_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [lfod_pkg::CNT_W-1:0]  lines_r, lines_nxt;
  logic [lfod_pkg::CNT_W-1:0]  drops_r, drops_nxt;

  logic [CW-1:0] lim;
  logic          is_term;
  logic          room;
  // one incrementer, shared by the store pointer and the read-out index
  logic [AW-1:0] inc_in;
  logic [AW-1:0] inc_out;
  logic          is_last;

  always_comb begin
    lim = CW'(max_chars);
    if (lim == '0) begin
      lim = CW'(1);
    end
    if (lim > MAX_LIM) begin
      lim = MAX_LIM;
    end
  end

  assign is_term = (byte_r == lfod_pkg::CHAR_LF) || (byte_r == lfod_pkg::CHAR_CR);
  assign room    = CW'(fill_r) < lim;
  assign inc_in  = (state_r == lfod_pkg::ST_PROC) ? fill_r : idx_r;
  assign inc_out = inc_in + AW'(1);
  assign is_last = (inc_out == fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfod_pkg::ST_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
      lines_r <= '0;
      drops_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      lines_r <= lines_nxt;
      drops_r <= drops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    byte_nxt    = byte_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    lines_nxt   = lines_r;
    drops_nxt   = drops_r;
    in_stall    = 1'b1;
    res_load    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = fill_r;
    ram_wr_data = byte_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r;

    case (state_r)
      lfod_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          byte_nxt  = in_rx_byte;
          state_nxt = lfod_pkg::ST_PROC;
        end
      end
      lfod_pkg::ST_PROC: begin
        if (is_term && (fill_r != '0)) begin
          // line complete: count it, then read it out from the start
          lines_nxt = lines_r + lfod_pkg::CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = lfod_pkg::ST_RD;
        end else if (out_free) begin
          res_load = 1'b1;
          if (!is_term) begin
            if (room) begin
              ram_wr_en = 1'b1;
              fill_nxt  = inc_out;
            end else begin
              // overlong line: drop it together with this byte
              fill_nxt  = '0;
              drops_nxt = drops_r + lfod_pkg::CNT_W'(1);
            end
          end
          state_nxt = lfod_pkg::ST_IDLE;
        end
      end
      lfod_pkg::ST_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = lfod_pkg::ST_EMIT;
      end
      lfod_pkg::ST_EMIT: begin
        if (out_free) begin
          res_load = 1'b1;
          if (is_last) begin
            fill_nxt  = '0;
            state_nxt = lfod_pkg::ST_IDLE;
          end else begin
            idx_nxt   = inc_out;
            state_nxt = lfod_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_nxt = lfod_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.lines_total = lines_nxt;
    res.drops_total = drops_nxt;
    if (state_r == lfod_pkg::ST_EMIT) begin
      res.has_char  = 1'b1;
      res.line_char = ram_rd_data;
      res.run_last  = is_last;
    end else begin
      res.has_char  = 1'b0;
      res.line_char = '0;
      res.run_last  = 1'b1;
    end
  end

endmodule

@@ design/line_framer_with_overflow_drop.sv @@
// A status result is loaded into the output register in the process step after its byte is taken; a line
// of N characters streams out after a count step, with a read step and an emit step per character.
// Each byte passes an accept step, then a process step that waits while the output register is full;
// a terminator that closes a line holds the input until the whole line has streamed out.
// in_stall is high while a byte is in work.
// Reset (rst_n, synchronous, active low) clears fill, counters and state; limit returns to 63.
`include "line_framer_with_overflow_drop_defines.svh"

module line_framer_with_overflow_drop #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfod_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_has_char,
  output logic [lfod_pkg::BYTE_W-1:0]   out_line_char,
  output logic                          out_run_last,
  output logic [lfod_pkg::CNT_W-1:0]    out_lines_total,
  output logic [lfod_pkg::CNT_W-1:0]    out_drops_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfod_pkg::CFG_W-1:0]    cfg_max_line_chars
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [lfod_pkg::CFG_W-1:0] max_chars_r, max_chars_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lfod_pkg::lfod_res_t        res_r;
  lfod_pkg::lfod_res_t        res;
  logic                       res_load;
  logic                       out_free;

  logic                       ram_wr_en;
  logic [AW-1:0]              ram_wr_addr;
  logic [lfod_pkg::BYTE_W-1:0] ram_wr_data;
  logic                       ram_rd_en;
  logic [AW-1:0]              ram_rd_addr;
  logic [lfod_pkg::BYTE_W-1:0] ram_rd_data;

  assign cfg_ready     = 1'b1;
  assign max_chars_nxt = (cfg_valid && cfg_ready) ? cfg_max_line_chars : max_chars_r;

  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = res_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= lfod_pkg::CFG_W'(63);
      out_valid_r <= 1'b0;
    end else begin
      max_chars_r <= max_chars_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  lfod_ram #(
    .DATA_W (lfod_pkg::BYTE_W),
    .DEPTH  (LINE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lfod_ctl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .max_chars   (max_chars_r),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_has_char    = res_r.has_char;
  assign out_line_char   = res_r.line_char;
  assign out_run_last    = res_r.run_last;
  assign out_lines_total = res_r.lines_total;
  assign out_drops_total = res_r.drops_total;

  `LFOD_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
  `LFOD_ASSERT_NOW(a_status_is_last, out_valid && !out_has_char,
    out_run_last && (out_line_char == '0))
  `LFOD_ASSERT_NEXT(a_lines_step, out_valid && !out_stall,
    !out_valid || (out_lines_total == $past(out_lines_total)) ||
    (out_lines_total == $past(out_lines_total) + 32'd1))

endmodule

@@ tb/lfod_checker.sv @@
`timescale 1ns / 1ps

module lfod_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [lfod_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_has_char,
  input  logic [lfod_pkg::BYTE_W-1:0] out_line_char,
  input  logic                        out_run_last,
  input  logic [lfod_pkg::CNT_W-1:0]  out_lines_total,
  input  logic [lfod_pkg::CNT_W-1:0]  out_drops_total,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [lfod_pkg::CFG_W-1:0]  cfg_max_line_chars,
  output int                          fault_count,
  output int                          results_due,
  output int                          results_seen
);

  logic [lfod_pkg::BYTE_W-1:0] held_chars [64];
  logic [lfod_pkg::CFG_W-1:0]  held_len;
  logic [lfod_pkg::CNT_W-1:0]  line_tally;
  logic [lfod_pkg::CNT_W-1:0]  drop_tally;
  logic [lfod_pkg::CFG_W-1:0]  len_cap;
  lfod_pkg::lfod_res_t         framed_due [$];

  initial begin
    fault_count  = 0;
    results_due  = 0;
    results_seen = 0;
  end

  task automatic flag_fault(input string msg);
    $display("%0t: %s", $time, msg);
    fault_count++;
  endtask

  task automatic compare_field(input string name, input logic [lfod_pkg::CNT_W-1:0] got,
                               input logic [lfod_pkg::CNT_W-1:0] want);
    if (got !== want)
      flag_fault($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
  endtask

  task automatic push_result(input logic has, input logic [lfod_pkg::BYTE_W-1:0] ch,
                             input logic last);
    lfod_pkg::lfod_res_t r;
    r.has_char    = has;
    r.line_char   = ch;
    r.run_last    = last;
    r.lines_total = line_tally;
    r.drops_total = drop_tally;
    framed_due.push_back(r);
  endtask

  // Work out every result that one received byte causes.
  task automatic frame_byte(input logic [lfod_pkg::BYTE_W-1:0] b);
    int eff_cap;
    int i;
    logic is_term;
    eff_cap = (len_cap == '0) ? 1 : int'(len_cap);
    is_term = (b == lfod_pkg::CHAR_LF) || (b == lfod_pkg::CHAR_CR);
    if (is_term && held_len != '0) begin
      line_tally = line_tally + 1;
      for (i = 0; i < held_len; i++)
        push_result(1'b1, held_chars[i], i == held_len - 1);
      held_len = '0;
    end else begin
      if (!is_term) begin
        if (held_len < eff_cap) begin
          held_chars[held_len] = b;
          held_len = held_len + 1'b1;
        end else begin
          // overlong: drop the line and the byte itself
          held_len   = '0;
          drop_tally = drop_tally + 1;
        end
      end
      push_result(1'b0, '0, 1'b1);
    end
  endtask

  task automatic check_result();
    lfod_pkg::lfod_res_t want;
    if (framed_due.size() == 0) begin
      flag_fault($sformatf("result with nothing expected: has_char %0b char %02h",
                           out_has_char, out_line_char));
      return;
    end
    want = framed_due.pop_front();
    results_seen++;
    compare_field("has_char", lfod_pkg::CNT_W'(out_has_char),
                  lfod_pkg::CNT_W'(want.has_char));
    compare_field("line_char", lfod_pkg::CNT_W'(out_line_char),
                  lfod_pkg::CNT_W'(want.line_char));
    compare_field("run_last", lfod_pkg::CNT_W'(out_run_last),
                  lfod_pkg::CNT_W'(want.run_last));
    compare_field("lines_total", out_lines_total, want.lines_total);
    compare_field("drops_total", out_drops_total, want.drops_total);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_len   = '0;
      line_tally = '0;
      drop_tally = '0;
      len_cap    = lfod_pkg::CFG_W'(63);
      framed_due.delete();
    end else begin
      if (out_valid && !out_stall)
        check_result();
      if (cfg_valid && cfg_ready)
        len_cap = cfg_max_line_chars;
      if (in_valid && !in_stall)
        frame_byte(in_rx_byte);
    end
    results_due = framed_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [lfod_pkg::BYTE_W-1:0] in_rx_byte;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_has_char;
  logic [lfod_pkg::BYTE_W-1:0] out_line_char;
  logic                        out_run_last;
  logic [lfod_pkg::CNT_W-1:0]  out_lines_total;
  logic [lfod_pkg::CNT_W-1:0]  out_drops_total;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [lfod_pkg::CFG_W-1:0]  cfg_max_line_chars;

  int fault_count;
  int results_due;
  int results_seen;
  int send_gap_pct;
  int recv_stall_pct;
  int bytes_sent;
  int line_cap;

  line_framer_with_overflow_drop dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_has_char       (out_has_char),
    .out_line_char      (out_line_char),
    .out_run_last       (out_run_last),
    .out_lines_total    (out_lines_total),
    .out_drops_total    (out_drops_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_line_chars (cfg_max_line_chars)
  );

  lfod_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_has_char       (out_has_char),
    .out_line_char      (out_line_char),
    .out_run_last       (out_run_last),
    .out_lines_total    (out_lines_total),
    .out_drops_total    (out_drops_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_line_chars (cfg_max_line_chars),
    .fault_count        (fault_count),
    .results_due        (results_due),
    .results_seen       (results_seen)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic send_byte(input logic [lfod_pkg::BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0)
      @(negedge clk);
  endtask

  task automatic write_limit(input logic [lfod_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_max_line_chars <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    line_cap = (v == '0) ? 1 : int'(v);
  endtask

  function automatic logic [lfod_pkg::BYTE_W-1:0] pick_text_byte();
    logic [lfod_pkg::BYTE_W-1:0] b;
    b = lfod_pkg::BYTE_W'($urandom_range(255));
    while (b == lfod_pkg::CHAR_LF || b == lfod_pkg::CHAR_CR)
      b = lfod_pkg::BYTE_W'($urandom_range(255));
    return b;
  endfunction

  // Random text, one terminator, sometimes followed by the other terminator as a pair.
  task automatic send_line(input int len);
    int k;
    logic use_cr;
    for (k = 0; k < len; k++)
      send_byte(pick_text_byte());
    use_cr = 1'($urandom_range(1));
    send_byte(use_cr ? lfod_pkg::CHAR_CR : lfod_pkg::CHAR_LF);
    if ($urandom_range(3) == 0)
      send_byte(use_cr ? lfod_pkg::CHAR_LF : lfod_pkg::CHAR_CR);
  endtask

  task automatic send_mix(input int quota);
    int first;
    int pick;
    int len;
    first = bytes_sent;
    while (bytes_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 74) begin
        if ($urandom_range(9) == 0)
          len = $urandom_range(1, line_cap);
        else
          len = $urandom_range(1, (line_cap < 8) ? line_cap : 8);
        send_line(len);
      end else if (pick < 80) begin
        send_line(line_cap + $urandom_range(1, 3));
      end else if (pick < 90) begin
        send_byte($urandom_range(1) ? lfod_pkg::CHAR_CR : lfod_pkg::CHAR_LF);
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(lfod_pkg::BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_rx_byte         = '0;
    out_stall          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_max_line_chars = '0;
    send_gap_pct       = 26;
    recv_stall_pct     = 54;
    bytes_sent         = 0;
    line_cap           = 63;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // terminators on an empty line
    send_byte(lfod_pkg::CHAR_CR);
    send_byte(lfod_pkg::CHAR_LF);
    // byte extremes in one line
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(lfod_pkg::CHAR_LF);
    // neighbours of the terminators, then CR LF
    send_byte(8'h09);
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_byte(8'h0E);
    send_byte(lfod_pkg::CHAR_CR);
    send_byte(lfod_pkg::CHAR_LF);
    // zero limit behaves as one character
    drain_results();
    write_limit(6'd0);
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(8'h7A);
    send_byte(lfod_pkg::CHAR_LF);
    // drop leaves an empty line behind
    drain_results();
    write_limit(6'd1);
    send_byte(8'h71);
    send_byte(8'h72);
    send_byte(lfod_pkg::CHAR_CR);

    drain_results();
    write_limit(6'd63);
    send_line(63);
    send_line(64);
    send_mix(30);
    drain_results();
    send_mix(30);

    drain_results();
    write_limit(lfod_pkg::CFG_W'($urandom_range(2, 20)));
    send_gap_pct   = 54;
    recv_stall_pct = 26;
    send_mix(70);

    drain_results();
    write_limit(6'd1);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_mix(40);

    drain_results();
    write_limit(lfod_pkg::CFG_W'($urandom_range(21, 62)));
    send_mix(50);

    drain_results();
    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("Summary: %0d bytes sent, %0d results checked, line limits 0, 1, 63 and between",
             bytes_sent, results_seen);
    $display("Summary: idling swapped between sender and receiver, then a full-rate stretch");
    if (fault_count == 0 && results_due == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/lfod_pkg.sv
design/lfod_ram.sv
design/lfod_ctl.sv
design/line_framer_with_overflow_drop.sv
tb/lfod_checker.sv
tb/tb_top.sv
